@@ sv/gbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid broad phase package
// Types, codes and constants that the grid broad phase modules share.
// ----------------------------------------------------------------------------
package gbp_pkg;

    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int CELL_W  = 19;
    localparam int COORD_W = 32;
    localparam int CSZ_W   = 23;
    localparam int STAT_W  = 3;
    localparam int FUNC_W  = 2;

    localparam logic [CSZ_W-1:0] CSZ_MIN = 23'd16384;
    localparam logic [CSZ_W-1:0] CSZ_MAX = 23'd6553600;
    localparam logic [CSZ_W-1:0] CSZ_RST = 23'd65536;

    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_LOADED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERSIZED = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_PAIR      = 3'd4;
    localparam logic [STAT_W-1:0] ST_NO_PAIR   = 3'd5;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd6;

    localparam logic [2:0] PS_CLEAR     = 3'd0;
    localparam logic [2:0] PS_LOAD      = 3'd1;
    localparam logic [2:0] PS_FULL      = 3'd2;
    localparam logic [2:0] PS_PAIR_MID  = 3'd3;
    localparam logic [2:0] PS_PAIR_LAST = 3'd4;
    localparam logic [2:0] PS_NO_PAIR   = 3'd5;
    localparam logic [2:0] PS_BAD       = 3'd6;

    typedef struct packed {
        logic                     ovs;
        logic signed [CELL_W-1:0] hz;
        logic signed [CELL_W-1:0] hy;
        logic signed [CELL_W-1:0] hx;
        logic signed [CELL_W-1:0] lz;
        logic signed [CELL_W-1:0] ly;
        logic signed [CELL_W-1:0] lx;
    } t_box;

    typedef struct packed {
        logic       load_in;
        logic       k_clr;
        logic       div_go;
        logic       cell_wr;
        logic       span_st;
        logic       prod1;
        logic       prod2;
        logic       box_wr;
        logic       cnt_clr;
        logic       rd_j;
        logic       left_cap;
        logic       j_clr;
        logic       j_inc;
        logic       pend_clr;
        logic       pend_upd;
        logic       post;
        logic [2:0] post_code;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              qbad;
        logic              div_done;
        logic              k_last;
        logic              out_free;
        logic              hit;
        logic              j_end;
        logic              pend;
    } t_sts;

endpackage

@@ sv/gbp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module gbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

@@ sv/gbp_div.sv @@
// ----------------------------------------------------------------------------
// Floor divider
// Restoring divider, one quotient bit a cycle, giving floor(dividend/divisor).
// ----------------------------------------------------------------------------
module gbp_div
    import gbp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [COORD_W-1:0] i_dividend,
    input  logic [CSZ_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic signed [CELL_W-1:0]  o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_cnt;
    logic [COORD_W-1:0]   r_mag;
    logic [CSZ_W:0]       r_rem;
    logic [CELL_W-1:0]    r_quo;
    logic                 r_neg;
    logic [CSZ_W:0]       n_sh;
    logic                 n_ge;

    assign n_sh = {r_rem[CSZ_W-1:0], r_mag[COORD_W-1]};
    assign n_ge = n_sh >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[COORD_W-1];
            r_mag <= i_dividend[COORD_W-1] ? COORD_W'(-i_dividend) : COORD_W'(i_dividend);
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_sh - {1'b0, i_divisor} : n_sh;
            r_mag <= {r_mag[COORD_W-2:0], 1'b0};
            r_quo <= {r_quo[CELL_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(~r_quo + CELL_W'(r_rem == '0)) : $signed(r_quo);

endmodule

@@ sv/gbp_datapath.sv @@
// ----------------------------------------------------------------------------
// Grid broad phase datapath
// Input latch, cell divider, span check, box store, overlap test and result
// register.
// ----------------------------------------------------------------------------
module gbp_datapath
    import gbp_pkg::*;
#(
    parameter int MAX_BOXES         = 64,
    parameter int MAX_CELLS_PER_BOX = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [199:0]       i_in_data,
    input  logic [FUNC_W-1:0]  i_in_func,
    input  logic               i_cfg_valid,
    input  logic [CSZ_W-1:0]   i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [IDX_W-1:0]   o_left,
    output logic [IDX_W-1:0]   o_right,
    output logic               o_last,
    output logic [CNT_W-1:0]   o_box_count,
    output logic [CNT_W-1:0]   o_over_total
);

    localparam int AW = $clog2(MAX_BOXES);
    localparam int SW = $clog2(MAX_CELLS_PER_BOX + 1);

    logic [CSZ_W-1:0]          r_csz;
    logic signed [COORD_W-1:0] r_coord [6];
    logic signed [CELL_W-1:0]  r_cell [6];
    logic [FUNC_W-1:0]         r_func;
    logic [IDX_W-1:0]          r_qidx;
    logic [2:0]                r_k;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_over;
    logic                      r_bad0;
    logic                      r_bad1;
    logic                      r_bad_last;
    logic [SW-1:0]             r_sp [3];
    logic [2*SW-1:0]           r_p1;
    logic [2*SW-1:0]           r_p2;
    t_box                      r_left;
    logic [IDX_W-1:0]          r_j;
    logic                      r_pend_v;
    logic [IDX_W-1:0]          r_pend_j;
    logic                      r_ovalid;

    logic                      n_div_done;
    logic signed [CELL_W-1:0]  n_quot;
    logic signed [21:0]        n_sp [3];
    logic                      n_bad0;
    logic                      n_bad;
    t_box                      n_box;
    t_box                      n_rd;
    logic                      n_ovl;
    logic                      n_out_free;
    logic [IDX_W-1:0]          n_lo;
    logic [IDX_W-1:0]          n_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csz <= CSZ_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_data < CSZ_MIN) begin
                r_csz <= CSZ_MIN;
            end else if (i_cfg_data > CSZ_MAX) begin
                r_csz <= CSZ_MAX;
            end else begin
                r_csz <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            for (int i = 0; i < 6; i++) begin
                r_coord[i] <= i_in_data[i*COORD_W +: COORD_W];
            end
            r_qidx <= i_in_data[6*COORD_W +: IDX_W];
            r_func <= i_in_func;
        end
    end

    gbp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (r_coord[r_k]),
        .i_divisor  (r_csz),
        .o_done     (n_div_done),
        .o_quot     (n_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.cell_wr) begin
            r_cell[r_k] <= n_quot;
            r_k         <= r_k + 3'd1;
        end
    end

    always_comb begin
        n_bad0 = 1'b0;
        for (int a = 0; a < 3; a++) begin
            n_sp[a] = 22'(r_cell[a+3]) - 22'(r_cell[a]) + 22'sd1;
            if (n_sp[a] <= 22'sd0 || n_sp[a] > $signed(22'(MAX_CELLS_PER_BOX))) begin
                n_bad0 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.span_st) begin
            r_bad0 <= n_bad0;
            for (int a = 0; a < 3; a++) begin
                r_sp[a] <= n_sp[a][SW-1:0];
            end
        end
        if (i_cmd.prod1) begin
            r_p1 <= r_sp[0] * r_sp[1];
        end
        if (i_cmd.prod2) begin
            r_p2  <= r_p1[SW-1:0] * r_sp[2];
            r_bad1 <= r_p1 > (2*SW)'(MAX_CELLS_PER_BOX);
        end
    end

    assign n_bad = r_bad0 | r_bad1 | (r_p2 > (2*SW)'(MAX_CELLS_PER_BOX));

    always_comb begin
        n_box.ovs = n_bad;
        n_box.lx  = r_cell[0];
        n_box.ly  = r_cell[1];
        n_box.lz  = r_cell[2];
        n_box.hx  = r_cell[3];
        n_box.hy  = r_cell[4];
        n_box.hz  = r_cell[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_over  <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_count <= '0;
            r_over  <= '0;
        end else if (i_cmd.box_wr) begin
            r_count <= r_count + CNT_W'(1);
            r_over  <= r_over + CNT_W'(n_bad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.box_wr) begin
            r_bad_last <= n_bad;
        end
    end

    gbp_ram #(
        .WIDTH ($bits(t_box)),
        .DEPTH (MAX_BOXES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.box_wr),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (n_box),
        .i_rd_addr (i_cmd.rd_j ? r_j[AW-1:0] : r_qidx[AW-1:0]),
        .o_rd_data (n_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.left_cap) begin
            r_left <= n_rd;
        end
        if (i_cmd.j_clr) begin
            r_j <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + IDX_W'(1);
        end
        if (i_cmd.pend_upd) begin
            r_pend_j <= r_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (i_cmd.pend_clr) begin
            r_pend_v <= 1'b0;
        end else if (i_cmd.pend_upd) begin
            r_pend_v <= 1'b1;
        end
    end

    assign n_ovl = r_left.ovs | n_rd.ovs |
                   (r_left.lx <= n_rd.hx && n_rd.lx <= r_left.hx &&
                    r_left.ly <= n_rd.hy && n_rd.ly <= r_left.hy &&
                    r_left.lz <= n_rd.hz && n_rd.lz <= r_left.hz);

    assign n_out_free = !r_ovalid || i_out_ready;
    assign n_lo = (r_qidx < r_pend_j) ? r_qidx : r_pend_j;
    assign n_hi = (r_qidx < r_pend_j) ? r_pend_j : r_qidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.post) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            o_box_count  <= r_count;
            o_over_total <= r_over;
            o_left       <= '0;
            o_right      <= '0;
            o_last       <= 1'b1;
            case (i_cmd.post_code)
                PS_CLEAR:     o_status <= ST_CLEARED;
                PS_LOAD:      o_status <= r_bad_last ? ST_OVERSIZED : ST_LOADED;
                PS_FULL:      o_status <= ST_FULL;
                PS_NO_PAIR:   o_status <= ST_NO_PAIR;
                PS_PAIR_MID, PS_PAIR_LAST: begin
                    o_status <= ST_PAIR;
                    o_left   <= n_lo;
                    o_right  <= n_hi;
                    o_last   <= (i_cmd.post_code == PS_PAIR_LAST);
                end
                default:      o_status <= ST_BAD_INDEX;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;

    assign o_sts.func     = r_func;
    assign o_sts.full     = (r_count == CNT_W'(MAX_BOXES));
    assign o_sts.qbad     = ({1'b0, r_qidx} >= r_count);
    assign o_sts.div_done = n_div_done;
    assign o_sts.k_last   = (r_k == 3'd5);
    assign o_sts.out_free = n_out_free;
    assign o_sts.hit      = (r_j != r_qidx) && n_ovl;
    assign o_sts.j_end    = ((CNT_W'(r_j) + CNT_W'(1)) == r_count);
    assign o_sts.pend     = r_pend_v;

endmodule

@@ sv/gbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Grid broad phase controller
// Sequences clear, load and query operations over the datapath.
// ----------------------------------------------------------------------------
module gbp_ctrl
    import gbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_DIVS = 4'd2;
    localparam logic [3:0] S_DIVW = 4'd3;
    localparam logic [3:0] S_SPAN = 4'd4;
    localparam logic [3:0] S_MUL1 = 4'd5;
    localparam logic [3:0] S_MUL2 = 4'd6;
    localparam logic [3:0] S_BOXW = 4'd7;
    localparam logic [3:0] S_QA   = 4'd8;
    localparam logic [3:0] S_QB   = 4'd9;
    localparam logic [3:0] S_QR   = 4'd10;
    localparam logic [3:0] S_QC   = 4'd11;
    localparam logic [3:0] S_QE   = 4'd12;
    localparam logic [3:0] S_POST = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [2:0] r_post;
    logic [2:0] n_post;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_post  = r_post;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.func)
                    FN_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_post        = PS_CLEAR;
                        n_state       = S_POST;
                    end
                    FN_LOAD: begin
                        if (i_sts.full) begin
                            n_post  = PS_FULL;
                            n_state = S_POST;
                        end else begin
                            o_cmd.k_clr = 1'b1;
                            n_state     = S_DIVS;
                        end
                    end
                    FN_QUERY: begin
                        if (i_sts.qbad) begin
                            n_post  = PS_BAD;
                            n_state = S_POST;
                        end else begin
                            n_state = S_QA;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DIVS: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIVW;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.cell_wr = 1'b1;
                    n_state       = i_sts.k_last ? S_SPAN : S_DIVS;
                end
            end
            S_SPAN: begin
                o_cmd.span_st = 1'b1;
                n_state       = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.prod1 = 1'b1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.prod2 = 1'b1;
                n_state     = S_BOXW;
            end
            S_BOXW: begin
                o_cmd.box_wr = 1'b1;
                n_post       = PS_LOAD;
                n_state      = S_POST;
            end
            S_QA: begin
                n_state = S_QB;
            end
            S_QB: begin
                o_cmd.left_cap = 1'b1;
                o_cmd.j_clr    = 1'b1;
                o_cmd.pend_clr = 1'b1;
                n_state        = S_QR;
            end
            S_QR: begin
                o_cmd.rd_j = 1'b1;
                n_state    = S_QC;
            end
            S_QC: begin
                o_cmd.rd_j = 1'b1;
                if (!(i_sts.hit && i_sts.pend && !i_sts.out_free)) begin
                    if (i_sts.hit) begin
                        o_cmd.pend_upd = 1'b1;
                        if (i_sts.pend) begin
                            o_cmd.post      = 1'b1;
                            o_cmd.post_code = PS_PAIR_MID;
                        end
                    end
                    if (i_sts.j_end) begin
                        n_state = S_QE;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                        n_state     = S_QR;
                    end
                end
            end
            S_QE: begin
                if (i_sts.out_free) begin
                    o_cmd.post      = 1'b1;
                    o_cmd.post_code = i_sts.pend ? PS_PAIR_LAST : PS_NO_PAIR;
                    n_state         = S_IDLE;
                end
            end
            S_POST: begin
                if (i_sts.out_free) begin
                    o_cmd.post      = 1'b1;
                    o_cmd.post_code = r_post;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_post  <= PS_CLEAR;
        end else begin
            r_state <= n_state;
            r_post  <= n_post;
        end
    end

endmodule

@@ sv/grid_broad_phase_pairs_top.sv @@
// ----------------------------------------------------------------------------
// Grid broad phase pairs, top level
// Uniform grid broad phase: loads boxes as cell ranges and reports pairs.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser carries the function (clear, load
// or query) and tdata the six Q16.16 corners and the query index. Results
// leave on the m_axis channel with the status in tuser and tlast on the final
// result of each item. The cell size is written on the cfg channel, which is
// always ready and must only be used while the block is idle.
// One item is worked on at a time; s_axis_tready is high only when idle.
// A load runs six floor divisions, one after another, through one shared
// restoring divider. A query reads the stored boxes one by one from the
// box memory and tests each against the query box for overlap.
// Results are held in an output register; when the receiver stalls the
// controller waits and nothing is lost, and the next item may be transferred
// while the final result is still waiting. Reset clears the counters and sets
// the cell size to 1.0; the box memory needs no clearing pass.
// ----------------------------------------------------------------------------
module grid_broad_phase_pairs_top
    import gbp_pkg::*;
#(
    parameter int MAX_BOXES         = 64,
    parameter int MAX_CELLS_PER_BOX = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, query_index, zero fill.
    input  logic [199:0]       s_axis_tdata,
    // func.
    input  logic [FUNC_W-1:0]  s_axis_tuser,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CSZ_W-1:0]   i_cfg_data,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // pair_left, pair_right, box_count, oversized_total, zero fill.
    output logic [31:0]        m_axis_tdata,
    // status.
    output logic [STAT_W-1:0]  m_axis_tuser,
    output logic               m_axis_tlast
);

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [IDX_W-1:0] w_left;
    logic [IDX_W-1:0] w_right;
    logic [CNT_W-1:0] w_box;
    logic [CNT_W-1:0] w_over;

    assign o_cfg_ready = 1'b1;

    gbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gbp_datapath #(
        .MAX_BOXES         (MAX_BOXES),
        .MAX_CELLS_PER_BOX (MAX_CELLS_PER_BOX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_data    (s_axis_tdata),
        .i_in_func    (s_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_status     (m_axis_tuser),
        .o_left       (w_left),
        .o_right      (w_right),
        .o_last       (m_axis_tlast),
        .o_box_count  (w_box),
        .o_over_total (w_over)
    );

    assign m_axis_tdata = {6'd0, w_over, w_box, w_right, w_left};

endmodule

@@ sv/gbp_checker.sv @@
// ----------------------------------------------------------------------------
// Grid broad phase checker
// Port level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gbp_checker
    import gbp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [31:0]       m_axis_tdata,
    input logic [STAT_W-1:0] m_axis_tuser,
    input logic              m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_PAIR |-> m_axis_tdata[5:0] < m_axis_tdata[11:6])
        else $error("pair indices not ordered");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_PAIR |-> m_axis_tdata[11:0] == 12'd0 && m_axis_tlast)
        else $error("single result malformed");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[25:19] <= m_axis_tdata[18:12])
        else $error("oversized total above box count");

endmodule

bind grid_broad_phase_pairs_top gbp_checker u_chk (.*);
